[hdl/rmf_pkg.sv]
// Shared package of the running median filter.
// Holds the configuration constants and the control structs used by the top
// level and by its cell and median modules. Depends on nothing.
`default_nettype none

package rmf_pkg;

	// Width of the window_length register and its value after reset.
	localparam int unsigned CFG_W = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd5;

	// Control that every cell of the sorted chain sees in the same cycle.
	typedef struct packed {
		logic load;   // a word is accepted, the cells take their new values
		logic first;  // this word refills the whole window
	} rmf_ctl_t;

	// Control of the median pipeline.
	typedef struct packed {
		logic adv;    // the pipeline moves one step
		logic valid;  // the cells hold a result that still has to be read
	} rmf_pipe_t;

endpackage

`default_nettype wire

[hdl/rmf_cell.sv]
// One cell of the sorted chain: holds one window value and its age.
// Works with its left and right neighbors to delete the oldest value and insert
// the new sample in the same cycle. Depends on rmf_pkg.
`default_nettype none

module rmf_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned SB    = 24,
	parameter int unsigned AGE_W = 6
) (
	input  wire                         clk,
	input  rmf_pkg::rmf_ctl_t           ctl,
	input  wire logic signed [SB-1:0]   sample,
	input  wire logic [AGE_W-1:0]       last_idx,
	// Left neighbor (one place lower in sorted order).
	input  wire logic signed [SB-1:0]   left_value,
	input  wire logic [AGE_W-1:0]       left_age,
	input  wire logic                   left_le,
	input  wire logic                   before_in,
	// Right neighbor (one place higher in sorted order).
	input  wire logic signed [SB-1:0]   right_value,
	input  wire logic [AGE_W-1:0]       right_age,
	input  wire logic                   right_le,
	// What this cell shows to its neighbors.
	output logic signed [SB-1:0]        cur_value,
	output logic [AGE_W-1:0]            cur_age,
	output logic                        cur_le,
	output logic                        before_out,
	output logic                        del,
	output logic signed [SB-1:0]        value
);

	logic signed [SB-1:0] value_q;
	logic [AGE_W-1:0]     age_q;
	logic                 active;
	logic                 is_last;
	logic signed [SB-1:0] c_value;
	logic [AGE_W-1:0]     c_age;
	logic                 c_le;
	logic signed [SB-1:0] p_value;
	logic [AGE_W-1:0]     p_age;
	logic                 p_le;
	logic signed [SB-1:0] nxt_value;
	logic [AGE_W-1:0]     nxt_age;

	// On a refill every cell holds the sample, with distinct ages so that the
	// lowest cell is the oldest.
	assign cur_value = ctl.first ? sample : value_q;
	assign cur_age   = ctl.first ? (last_idx - AGE_W'(IDX)) : age_q;
	assign cur_le    = (cur_value <= sample);

	assign active     = (AGE_W'(IDX) <= last_idx);
	assign is_last    = (AGE_W'(IDX) == last_idx);
	assign del        = active && (cur_age == last_idx);
	assign before_out = before_in | del;

	// This place and the one below it, after the oldest value is taken out.
	assign c_value = before_out ? right_value : cur_value;
	assign c_age   = before_out ? right_age   : cur_age;
	assign c_le    = before_out ? right_le    : cur_le;
	assign p_value = before_in  ? cur_value   : left_value;
	assign p_age   = before_in  ? cur_age     : left_age;
	assign p_le    = before_in  ? cur_le      : left_le;

	always_comb begin
		priority if (!is_last && c_le) begin
			nxt_value = c_value;
			nxt_age   = c_age + 1'b1;
		end else if (p_le) begin
			nxt_value = sample;
			nxt_age   = '0;
		end else begin
			nxt_value = p_value;
			nxt_age   = p_age + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && active) begin
			value_q <= nxt_value;
			age_q   <= nxt_age;
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

[hdl/rmf_median.sv]
// Median read-out of the running median filter: picks the two middle cells,
// then averages them with truncation toward zero into the output register.
// Depends on rmf_pkg.
`default_nettype none

module rmf_median #(
	parameter int unsigned MAX_WINDOW = 64,
	parameter int unsigned SB         = 24,
	parameter int unsigned AGE_W      = 6
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  rmf_pkg::rmf_pipe_t          pipe,
	input  wire logic signed [SB-1:0]   vals [MAX_WINDOW],
	input  wire logic [AGE_W-1:0]       lo_idx,
	input  wire logic [AGE_W-1:0]       hi_idx,
	output logic                        out_valid,
	output logic signed [SB-1:0]        out_median
);

	logic [SB-1:0]        lo_sel;
	logic [SB-1:0]        hi_sel;
	logic signed [SB-1:0] lo_s2;
	logic signed [SB-1:0] hi_s2;
	logic                 valid_s2;
	logic signed [SB:0]   sum;
	logic signed [SB:0]   adj;
	logic signed [SB-1:0] median_q;
	logic                 valid_q;

	// AND-OR selection of the two middle cells.
	always_comb begin
		lo_sel = '0;
		hi_sel = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			lo_sel = lo_sel | (vals[i] & {SB{lo_idx == AGE_W'(i)}});
			hi_sel = hi_sel | (vals[i] & {SB{hi_idx == AGE_W'(i)}});
		end
	end

	// For an odd window both indexes are the middle, so the average is exact.
	// Adding the sign bit before the shift rounds a negative sum toward zero.
	assign sum = {lo_s2[SB-1], lo_s2} + {hi_s2[SB-1], hi_s2};
	assign adj = sum + (SB+1)'(sum[SB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (pipe.adv) begin
			valid_s2 <= pipe.valid;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.adv) begin
			lo_s2    <= lo_sel;
			hi_s2    <= hi_sel;
			median_q <= adj[SB:1];
		end
	end

	assign out_valid  = valid_q;
	assign out_median = median_q;

endmodule

`default_nettype wire

[hdl/running_median_filter_unit.sv]
// Top level of the running median filter: configuration register, the chain
// of sorted cells and the median read-out pipeline.
// Depends on rmf_pkg, rmf_cell and rmf_median.
//
//   channel        handshake                     payload
//   sample in      sample_valid / sample_stall   sample (SAMPLE_BITS, signed)
//   median out     median_valid / median_stall   median (SAMPLE_BITS, signed)
//   configuration  window_length_we              window_length (7 bits)
//
// One word is accepted per cycle while the output is not stalled. Its median is
// valid at the output once it has reached the output register.
// The sorted chain updates in the accept cycle, then the two middle cells are
// selected, then averaged into the output register.
// Reset empties the pipeline, sets the window to 5 and arms a refill; there is
// no clearing pass. A stalled output word freezes the whole pipeline, and the
// input is stalled for exactly as long.
`default_nettype none

module running_median_filter_unit #(
	parameter int unsigned MAX_WINDOW  = 64,
	parameter int unsigned SAMPLE_BITS = 24
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                window_length_we,
	input  wire logic [rmf_pkg::CFG_W-1:0]     window_length,
	input  wire                                sample_valid,
	output logic                               sample_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                               median_valid,
	input  wire                                median_stall,
	output logic signed [SAMPLE_BITS-1:0]      median
);

	// Ages run from 0 to the window length minus one; cell indexes share the width.
	localparam int unsigned AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);

	// Window length as used: zero counts as one, anything above the chain
	// length is held at the chain length.
	function automatic logic [LEN_W-1:0] sat_len(input logic [rmf_pkg::CFG_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (int'(v) > int'(MAX_WINDOW)) begin
			r = LEN_W'(MAX_WINDOW);
		end else begin
			r = LEN_W'(v);
		end
		return r;
	endfunction

	logic [LEN_W-1:0]             len_q;
	logic                         first_q;
	logic                         cells_valid_q;
	logic                         adv;
	logic                         acc;
	logic [AGE_W-1:0]             last_idx;
	logic [AGE_W-1:0]             mid_idx;
	logic [AGE_W-1:0]             lo_idx;
	rmf_pkg::rmf_ctl_t            cell_ctl;
	rmf_pkg::rmf_pipe_t           pipe;

	logic signed [SAMPLE_BITS-1:0] cur_value [MAX_WINDOW];
	logic [AGE_W-1:0]              cur_age   [MAX_WINDOW];
	logic                          cur_le    [MAX_WINDOW];
	logic                          del_below [MAX_WINDOW+1];
	logic [MAX_WINDOW-1:0]         del_vec;
	logic signed [SAMPLE_BITS-1:0] vals      [MAX_WINDOW];

	// The pipeline moves unless a finished word waits at a stalled output.
	assign adv          = !(median_valid && median_stall);
	assign sample_stall = !adv;
	assign acc          = sample_valid && adv;

	// Window geometry. For an odd length both middle indexes coincide.
	assign last_idx = AGE_W'(len_q - 1'b1);
	assign mid_idx  = AGE_W'(len_q >> 1);
	assign lo_idx   = len_q[0] ? mid_idx : (mid_idx - 1'b1);

	// A configuration write always arms a refill, even with the same length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q         <= sat_len(rmf_pkg::WINDOW_RESET);
			first_q       <= 1'b1;
			cells_valid_q <= 1'b0;
		end else begin
			if (window_length_we) begin
				len_q   <= sat_len(window_length);
				first_q <= 1'b1;
			end else if (acc) begin
				first_q <= 1'b0;
			end
			if (adv) begin
				cells_valid_q <= acc;
			end
		end
	end

	assign cell_ctl.load  = acc;
	assign cell_ctl.first = first_q;

	// The deletion flag ripples up the chain: a cell sees whether the oldest
	// value sits below it, and so whether its neighbors have moved down.
	assign del_below[0] = 1'b0;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] l_value;
		logic [AGE_W-1:0]              l_age;
		logic                          l_le;
		logic signed [SAMPLE_BITS-1:0] r_value;
		logic [AGE_W-1:0]              r_age;
		logic                          r_le;

		// The bottom cell takes the sample unless it is not the last cell and the value
		// at its place after the deletion is no larger; the top cell never looks above itself.
		if (i == 0) begin : g_lo_end
			assign l_value = sample;
			assign l_age   = '0;
			assign l_le    = 1'b1;
		end else begin : g_lo_mid
			assign l_value = cur_value[i-1];
			assign l_age   = cur_age[i-1];
			assign l_le    = cur_le[i-1];
		end
		if (i == MAX_WINDOW - 1) begin : g_hi_end
			assign r_value = '0;
			assign r_age   = '0;
			assign r_le    = 1'b0;
		end else begin : g_hi_mid
			assign r_value = cur_value[i+1];
			assign r_age   = cur_age[i+1];
			assign r_le    = cur_le[i+1];
		end

		rmf_cell #(
			.IDX   (i),
			.SB    (SAMPLE_BITS),
			.AGE_W (AGE_W)
		) u_cell (
			.clk         (clk),
			.ctl         (cell_ctl),
			.sample      (sample),
			.last_idx    (last_idx),
			.left_value  (l_value),
			.left_age    (l_age),
			.left_le     (l_le),
			.before_in   (del_below[i]),
			.right_value (r_value),
			.right_age   (r_age),
			.right_le    (r_le),
			.cur_value   (cur_value[i]),
			.cur_age     (cur_age[i]),
			.cur_le      (cur_le[i]),
			.before_out  (del_below[i+1]),
			.del         (del_vec[i]),
			.value       (vals[i])
		);
	end

	assign pipe.adv   = adv;
	assign pipe.valid = cells_valid_q;

	rmf_median #(
		.MAX_WINDOW (MAX_WINDOW),
		.SB         (SAMPLE_BITS),
		.AGE_W      (AGE_W)
	) u_median (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe       (pipe),
		.vals       (vals),
		.lo_idx     (lo_idx),
		.hi_idx     (mid_idx),
		.out_valid  (median_valid),
		.out_median (median)
	);

	// Ages in the window are distinct, so at most one cell drops out per word.
	a_one_delete: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> $onehot0(del_vec))
		else $error("more than one cell holds the oldest value");

	// A configuration write arms the refill.
	a_cfg_arms: assert property (@(posedge clk) disable iff (!arst_n)
		window_length_we |=> first_q)
		else $error("refill not armed after a configuration write");

	// The refill is used up by the first accepted word.
	a_first_used: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !window_length_we) |=> !first_q)
		else $error("refill still armed after an accepted word");

	// An accepted word leaves a result in the cells for the read-out stage.
	a_cells_valid: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> cells_valid_q)
		else $error("accepted word lost before the read-out stage");

endmodule

`default_nettype wire
